@@ design/msud_pkg.sv @@
// ----------------------------------------------------------------------------
// msud_pkg
// Shared types, codes, reset values and BCD step functions for the
// minute/second up/down timer.
// ----------------------------------------------------------------------------
package msud_pkg;

	// field widths
	localparam int PERIOD_W = 16;
	localparam int LED_W    = 8;
	localparam int CIDX_W   = 8;

	// request codes
	typedef enum logic [1:0] {
		REQ_TICK      = 2'd0,
		REQ_MODE      = 2'd1,
		REQ_COUNT_KEY = 2'd2,
		REQ_FLASH_KEY = 2'd3
	} req_t;

	// run modes
	typedef enum logic [1:0] {
		MODE_DOWN  = 2'd0,
		MODE_PAUSE = 2'd1,
		MODE_UP    = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_SECOND_PERIOD      = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] CFG_SECOND_PERIOD_FAST = CIDX_W'(1);
	localparam logic [CIDX_W-1:0] CFG_FLASH_PERIOD       = CIDX_W'(2);
	localparam logic [CIDX_W-1:0] CFG_FLASH_PERIOD_FAST  = CIDX_W'(3);
	localparam logic [CIDX_W-1:0] CFG_FLASH_KEY_RELOAD   = CIDX_W'(4);
	localparam logic [CIDX_W-1:0] CFG_LED_PATTERN        = CIDX_W'(5);

	// reset values
	localparam logic [PERIOD_W-1:0] RST_SECOND_PERIOD      = PERIOD_W'(1000);
	localparam logic [PERIOD_W-1:0] RST_SECOND_PERIOD_FAST = PERIOD_W'(200);
	localparam logic [PERIOD_W-1:0] RST_FLASH_PERIOD       = PERIOD_W'(500);
	localparam logic [PERIOD_W-1:0] RST_FLASH_PERIOD_FAST  = PERIOD_W'(100);
	localparam logic [PERIOD_W-1:0] RST_FLASH_KEY_RELOAD   = PERIOD_W'(200);
	localparam logic [LED_W-1:0]    RST_LED_PATTERN        = LED_W'(4);
	localparam logic [LED_W-1:0]    LED_ALL_OFF            = 8'hFF;

	// configuration register set
	typedef struct packed {
		logic [PERIOD_W-1:0] second_period;
		logic [PERIOD_W-1:0] second_period_fast;
		logic [PERIOD_W-1:0] flash_period;
		logic [PERIOD_W-1:0] flash_period_fast;
		logic [PERIOD_W-1:0] flash_key_reload;
		logic [LED_W-1:0]    led_pattern;
	} cfg_regs_t;

	// mm:ss time as BCD digits
	typedef struct packed {
		logic [2:0] min_tens;
		logic [3:0] min_ones;
		logic [2:0] sec_tens;
		logic [3:0] sec_ones;
	} time_t;

	localparam time_t TIME_RESET = '{min_tens: 3'd5, min_ones: 4'd9,
		sec_tens: 3'd5, sec_ones: 4'd0};
	localparam time_t TIME_ZERO  = '{min_tens: 3'd0, min_ones: 4'd0,
		sec_tens: 3'd0, sec_ones: 4'd0};

	// result of one item
	typedef struct packed {
		time_t            tm;
		logic [LED_W-1:0] led_drive;
		mode_t            mode_now;
		logic             second_event;
	} result_t;

	// one second up, 59:59 wraps to 00:00
	function automatic time_t time_up(time_t t);
		time_t r;
		r = t;
		if (t.sec_ones != 4'd9) begin
			r.sec_ones = t.sec_ones + 4'd1;
		end else begin
			r.sec_ones = 4'd0;
			if (t.sec_tens != 3'd5) begin
				r.sec_tens = t.sec_tens + 3'd1;
			end else begin
				r.sec_tens = 3'd0;
				if (t.min_ones != 4'd9) begin
					r.min_ones = t.min_ones + 4'd1;
				end else begin
					r.min_ones = 4'd0;
					if (t.min_tens != 3'd5) begin
						r.min_tens = t.min_tens + 3'd1;
					end else begin
						r.min_tens = 3'd0;
					end
				end
			end
		end
		return r;
	endfunction

	// one second down, 00:00 wraps to 59:59
	function automatic time_t time_down(time_t t);
		time_t r;
		r = t;
		if (t.sec_ones != 4'd0) begin
			r.sec_ones = t.sec_ones - 4'd1;
		end else begin
			r.sec_ones = 4'd9;
			if (t.sec_tens != 3'd0) begin
				r.sec_tens = t.sec_tens - 3'd1;
			end else begin
				r.sec_tens = 3'd5;
				if (t.min_ones != 4'd0) begin
					r.min_ones = t.min_ones - 4'd1;
				end else begin
					r.min_ones = 4'd9;
					if (t.min_tens != 3'd0) begin
						r.min_tens = t.min_tens - 3'd1;
					end else begin
						r.min_tens = 3'd5;
					end
				end
			end
		end
		return r;
	endfunction

endpackage

@@ design/msud_req_if.sv @@
// ----------------------------------------------------------------------------
// msud_req_if
// Request channel: one tick, mode command or key press per item.
// ----------------------------------------------------------------------------
interface msud_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       key_held;
	logic [1:0] mode_cmd;

	modport source (output valid, output req_type, output key_held, output mode_cmd,
		input ready);
	modport sink (input valid, input req_type, input key_held, input mode_cmd,
		output ready);
endinterface

@@ design/msud_rsp_if.sv @@
// ----------------------------------------------------------------------------
// msud_rsp_if
// Result channel: time digits, LED byte, mode and second flag per item.
// ----------------------------------------------------------------------------
interface msud_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] min_tens;
	logic [3:0] min_ones;
	logic [2:0] sec_tens;
	logic [3:0] sec_ones;
	logic [7:0] led_drive;
	logic [1:0] mode_now;
	logic       second_event;

	modport source (output valid, output min_tens, output min_ones, output sec_tens,
		output sec_ones, output led_drive, output mode_now, output second_event,
		input ready);
	modport sink (input valid, input min_tens, input min_ones, input sec_tens,
		input sec_ones, input led_drive, input mode_now, input second_event,
		output ready);
endinterface

@@ design/msud_cfg_if.sv @@
// ----------------------------------------------------------------------------
// msud_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface msud_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/msud_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// msud_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module msud_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [7:0]          wr_index,
	input  logic [15:0]         wr_data,
	output msud_pkg::cfg_regs_t regs
);
	import msud_pkg::*;

	cfg_regs_t regs_q;

	// register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.second_period      <= RST_SECOND_PERIOD;
			regs_q.second_period_fast <= RST_SECOND_PERIOD_FAST;
			regs_q.flash_period       <= RST_FLASH_PERIOD;
			regs_q.flash_period_fast  <= RST_FLASH_PERIOD_FAST;
			regs_q.flash_key_reload   <= RST_FLASH_KEY_RELOAD;
			regs_q.led_pattern        <= RST_LED_PATTERN;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SECOND_PERIOD:      regs_q.second_period      <= wr_data;
				CFG_SECOND_PERIOD_FAST: regs_q.second_period_fast <= wr_data;
				CFG_FLASH_PERIOD:       regs_q.flash_period       <= wr_data;
				CFG_FLASH_PERIOD_FAST:  regs_q.flash_period_fast  <= wr_data;
				CFG_FLASH_KEY_RELOAD:   regs_q.flash_key_reload   <= wr_data;
				CFG_LED_PATTERN:        regs_q.led_pattern        <= wr_data[LED_W-1:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;
endmodule

@@ design/msud_prescaler.sv @@
// ----------------------------------------------------------------------------
// msud_prescaler
// Tick-driven countdown: decrements unless paused, reloads and fires at zero,
// and can be reloaded directly by a key press.
// ----------------------------------------------------------------------------
module msud_prescaler #(
	parameter logic [15:0] RESET_COUNT = 16'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick,
	input  logic        pause,
	input  logic        held,
	input  logic [15:0] period,
	input  logic [15:0] period_fast,
	input  logic        load,
	input  logic [15:0] load_value,
	output logic        fire
);
	logic [15:0] count_q;
	logic [15:0] count_d;

	// next count and fire flag
	always_comb begin
		count_d = count_q;
		fire    = 1'b0;
		if (tick) begin
			if (count_q != 16'd0) begin
				if (!pause) begin
					count_d = count_q - 16'd1;
				end
			end else begin
				count_d = held ? period_fast : period;
				fire    = 1'b1;
			end
		end else if (load) begin
			count_d = load_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= RESET_COUNT;
		end else begin
			count_q <= count_d;
		end
	end
endmodule

@@ design/msud_core.sv @@
// ----------------------------------------------------------------------------
// msud_core
// Timer state: BCD time, run mode, flash phase and LED byte, plus the two
// prescalers. Updates on each stepped item and presents the state after it.
// ----------------------------------------------------------------------------
module msud_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [1:0]          req_type,
	input  logic                key_held,
	input  logic [1:0]          mode_cmd,
	input  msud_pkg::cfg_regs_t cfg,
	output msud_pkg::result_t   result
);
	import msud_pkg::*;

	time_t            time_q;
	time_t            time_d;
	mode_t            mode_q;
	mode_t            mode_d;
	logic             phase_q;
	logic             phase_d;
	logic [LED_W-1:0] led_q;
	logic [LED_W-1:0] led_d;
	logic             tick;
	logic             count_key;
	logic             flash_key;
	logic             pause;
	logic             sec_fire;
	logic             flash_fire;

	// request decode
	assign tick      = step && (req_t'(req_type) == REQ_TICK);
	assign count_key = step && (req_t'(req_type) == REQ_COUNT_KEY);
	assign flash_key = step && (req_t'(req_type) == REQ_FLASH_KEY);
	assign pause     = (mode_q == MODE_PAUSE);

	// second prescaler, reloaded fast by the count key
	msud_prescaler #(
		.RESET_COUNT (RST_SECOND_PERIOD)
	) u_sec_pre (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick),
		.pause       (pause),
		.held        (key_held),
		.period      (cfg.second_period),
		.period_fast (cfg.second_period_fast),
		.load        (count_key),
		.load_value  (cfg.second_period_fast),
		.fire        (sec_fire)
	);

	// flash prescaler, reloaded by the flash key
	msud_prescaler #(
		.RESET_COUNT (RST_FLASH_PERIOD)
	) u_flash_pre (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick),
		.pause       (pause),
		.held        (key_held),
		.period      (cfg.flash_period),
		.period_fast (cfg.flash_period_fast),
		.load        (flash_key),
		.load_value  (cfg.flash_key_reload),
		.fire        (flash_fire)
	);

	// time and mode update
	always_comb begin
		time_d = time_q;
		mode_d = mode_q;
		if (step) begin
			case (req_t'(req_type))
				REQ_TICK: begin
					if (sec_fire) begin
						case (mode_q)
							MODE_DOWN: time_d = time_down(time_q);
							MODE_CLEAR: begin
								time_d = TIME_ZERO;
								mode_d = MODE_UP;
							end
							default: time_d = time_up(time_q);
						endcase
					end
				end
				REQ_MODE:      mode_d = mode_t'(mode_cmd);
				REQ_COUNT_KEY: time_d = time_up(time_q);
				default: ;
			endcase
		end
	end

	// flash phase and led byte
	always_comb begin
		phase_d = phase_q;
		led_d   = led_q;
		if (tick && flash_fire) begin
			phase_d = ~phase_q;
			led_d   = (phase_d == 1'b0) ? ~cfg.led_pattern : LED_ALL_OFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= TIME_RESET;
			mode_q  <= MODE_UP;
			phase_q <= 1'b0;
			led_q   <= LED_ALL_OFF;
		end else begin
			time_q  <= time_d;
			mode_q  <= mode_d;
			phase_q <= phase_d;
			led_q   <= led_d;
		end
	end

	// result reflects the state after this item
	assign result.tm           = time_d;
	assign result.led_drive    = led_d;
	assign result.mode_now     = mode_d;
	assign result.second_event = tick && sec_fire;
endmodule

@@ design/minute_second_up_down_timer.sv @@
// ----------------------------------------------------------------------------
// minute_second_up_down_timer
// mm:ss BCD up/down timer with a flashing active-low LED byte.
// ----------------------------------------------------------------------------
// One result item comes out for every request item, in order. An accepted
// item is held in the input register; when it advances, the timer state
// updates and the result register loads on the same edge. The whole state
// update is combinational logic between the two registers, so the block
// takes one item every clock while the result side keeps up; when the
// result register is full and not taken, the input register holds one more
// item and then ready drops. Configuration writes are always taken and should
// be issued only while no item is in flight. There is no clearing pass after
// reset.
module minute_second_up_down_timer (
	input  logic       clk,
	input  logic       arst_n,
	msud_req_if.sink   req,
	msud_rsp_if.source rsp,
	msud_cfg_if.sink   cfg
);
	import msud_pkg::*;

	logic       valid_s1;
	logic [1:0] req_type_s1;
	logic       key_held_s1;
	logic [1:0] mode_cmd_s1;
	logic       advance;
	logic       rsp_valid_q;
	result_t    rsp_q;
	result_t    core_result;
	cfg_regs_t  cfg_regs;

	// item moves on when the result register is free or being drained
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// configuration registers
	msud_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.regs     (cfg_regs)
	);

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			key_held_s1 <= req.key_held;
			mode_cmd_s1 <= req.mode_cmd;
		end
	end

	// timer state and next-state logic
	msud_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.req_type (req_type_s1),
		.key_held (key_held_s1),
		.mode_cmd (mode_cmd_s1),
		.cfg      (cfg_regs),
		.result   (core_result)
	);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= core_result;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.min_tens     = rsp_q.tm.min_tens;
	assign rsp.min_ones     = rsp_q.tm.min_ones;
	assign rsp.sec_tens     = rsp_q.tm.sec_tens;
	assign rsp.sec_ones     = rsp_q.tm.sec_ones;
	assign rsp.led_drive    = rsp_q.led_drive;
	assign rsp.mode_now     = rsp_q.mode_now;
	assign rsp.second_event = rsp_q.second_event;
endmodule
